// ===== rtl/pglm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pglm_pkg
// Shared types and constants for the pixel gamma table / mean colour block.
// ----------------------------------------------------------------------------
package pglm_pkg;

   localparam int MAX_PIXELS = 16777216;
   localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
   localparam int SUM_W      = $clog2(longint'(MAX_PIXELS) * 255 + 1);

   localparam int PIX_W      = 8;
   localparam int TBL_DEPTH  = 256;
   localparam int TBL_AW     = $clog2(TBL_DEPTH);
   localparam int CHANNELS   = 3;

   localparam int FRAC_W     = 8;
   localparam int MEAN_W     = 16;
   localparam int MEAN_MAX   = 255 << FRAC_W;
   localparam int DIV_STEPS  = MEAN_W;
   localparam int DIV_CW     = $clog2(DIV_STEPS);

   localparam int CMD_DEPTH  = 4;
   localparam int CMD_PW     = $clog2(CMD_DEPTH);
   localparam int CMD_CW     = $clog2(CMD_DEPTH + 1);
   localparam int OUT_DEPTH  = 4;
   localparam int OUT_PW     = $clog2(OUT_DEPTH);
   localparam int OUT_CW     = $clog2(OUT_DEPTH + 1);

   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;
   localparam int CSR_IW     = CSR_AW - 2;

   localparam logic [CSR_IW-1:0] REG_GAMMA_BYPASS = CSR_IW'(0);

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_PIXEL = 1'b1;

   typedef struct packed {
      logic             action;
      logic [TBL_AW-1:0] table_index;
      logic [PIX_W-1:0] table_value;
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] alpha;
      logic             last_pixel;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0]  out_red;
      logic [PIX_W-1:0]  out_green;
      logic [PIX_W-1:0]  out_blue;
      logic [PIX_W-1:0]  out_alpha;
      logic [MEAN_W-1:0] mean_red;
      logic [MEAN_W-1:0] mean_green;
      logic [MEAN_W-1:0] mean_blue;
      logic              image_done;
   } rsp_type;

   // classified item as held in the command queue
   typedef struct packed {
      logic              is_pixel;
      logic              last;
      logic [TBL_AW-1:0] tbl_index;
      logic [PIX_W-1:0]  tbl_value;
      logic [PIX_W-1:0]  red;
      logic [PIX_W-1:0]  green;
      logic [PIX_W-1:0]  blue;
      logic [PIX_W-1:0]  alpha;
   } cmd_type;

   typedef struct packed {
      logic              div_busy;
      logic              hold_valid;
      logic [OUT_CW-1:0] out_count;
   } back_status_type;

endpackage
`default_nettype wire

// ===== rtl/pglm_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pglm_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module pglm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== rtl/pglm_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pglm_div
// Three-lane restoring divider for the image means, one quotient bit per
// cycle: mean = floor(sum * 256 / count).
// ----------------------------------------------------------------------------
module pglm_div (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           start,
   input  logic [pglm_pkg::CHANNELS-1:0][pglm_pkg::SUM_W-1:0] sum,
   input  logic [pglm_pkg::CNT_W-1:0]                     count,
   output logic                                           busy,
   output logic [pglm_pkg::CHANNELS-1:0][pglm_pkg::MEAN_W-1:0] mean
);

   logic [pglm_pkg::CHANNELS-1:0][pglm_pkg::CNT_W-1:0]  rem_ff, rem_in;
   logic [pglm_pkg::CHANNELS-1:0][pglm_pkg::MEAN_W-1:0] low_ff, low_in;
   logic [pglm_pkg::CHANNELS-1:0][pglm_pkg::MEAN_W-1:0] quot_ff, quot_in;
   logic [pglm_pkg::CHANNELS-1:0][pglm_pkg::CNT_W:0]    trial;
   logic [pglm_pkg::CNT_W-1:0]                          den_ff, den_in;
   logic                                                busy_ff, busy_in;
   logic [pglm_pkg::DIV_CW-1:0]                         step_ff, step_in;

   // quotient fits MEAN_W bits, so the top part of sum*256 (sum >> 8) is
   // already below the divisor and seeds the remainder
   always_comb begin
      rem_in  = rem_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      busy_in = busy_ff;
      step_in = step_ff;
      trial   = '0;
      if (start) begin
         for (int c = 0; c < pglm_pkg::CHANNELS; c++) begin
            rem_in[c]  = pglm_pkg::CNT_W'(sum[c] >> pglm_pkg::FRAC_W);
            low_in[c]  = {sum[c][pglm_pkg::FRAC_W-1:0],
                          {(pglm_pkg::MEAN_W - pglm_pkg::FRAC_W){1'b0}}};
            quot_in[c] = '0;
         end
         den_in  = count;
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff) begin
         for (int c = 0; c < pglm_pkg::CHANNELS; c++) begin
            trial[c] = {rem_ff[c], low_ff[c][pglm_pkg::MEAN_W-1]};
            if (trial[c] >= {1'b0, den_ff}) begin
               rem_in[c]  = pglm_pkg::CNT_W'(trial[c] - {1'b0, den_ff});
               quot_in[c] = {quot_ff[c][pglm_pkg::MEAN_W-2:0], 1'b1};
            end else begin
               rem_in[c]  = trial[c][pglm_pkg::CNT_W-1:0];
               quot_in[c] = {quot_ff[c][pglm_pkg::MEAN_W-2:0], 1'b0};
            end
            low_in[c] = {low_ff[c][pglm_pkg::MEAN_W-2:0], 1'b0};
         end
         if (step_ff == pglm_pkg::DIV_CW'(pglm_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
   end

   assign busy = busy_ff;
   assign mean = quot_ff;

endmodule
`default_nettype wire

// ===== rtl/pglm_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pglm_front
// Input side: takes items, sorts table loads from pixels and queues them
// for the back end.
// ----------------------------------------------------------------------------
module pglm_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  pglm_pkg::req_type req_data,
   output logic              cmd_valid,
   output pglm_pkg::cmd_type cmd_data,
   input  logic              cmd_pop
);

   pglm_pkg::cmd_type             queue_ff [pglm_pkg::CMD_DEPTH];
   pglm_pkg::cmd_type             cmd_in;
   logic [pglm_pkg::CMD_PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [pglm_pkg::CMD_PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [pglm_pkg::CMD_CW-1:0]   count_ff, count_in;
   logic                          accept;
   logic                          take;

   assign full      = (count_ff == pglm_pkg::CMD_CW'(pglm_pkg::CMD_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign accept    = push && !full;
   assign take      = cmd_pop && cmd_valid;
   assign cmd_data  = queue_ff[rd_ptr_ff];

   always_comb begin
      cmd_in.is_pixel  = (req_data.action == pglm_pkg::ACT_PIXEL);
      cmd_in.last      = (req_data.action == pglm_pkg::ACT_PIXEL) && req_data.last_pixel;
      cmd_in.tbl_index = req_data.table_index;
      cmd_in.tbl_value = req_data.table_value;
      cmd_in.red       = req_data.red;
      cmd_in.green     = req_data.green;
      cmd_in.blue      = req_data.blue;
      cmd_in.alpha     = req_data.alpha;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (accept) begin
         wr_ptr_in = (wr_ptr_ff == pglm_pkg::CMD_PW'(pglm_pkg::CMD_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == pglm_pkg::CMD_PW'(pglm_pkg::CMD_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({accept, take})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (accept) begin
         queue_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/pglm_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pglm_back
// Execution side: table writes, lookups, channel sums, mean division and
// the result queue.
// ----------------------------------------------------------------------------
module pglm_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      bypass,
   input  logic                      cmd_valid,
   input  pglm_pkg::cmd_type         cmd_data,
   output logic                      cmd_pop,
   output logic                      empty,
   input  logic                      pop,
   output pglm_pkg::rsp_type         rsp_data,
   output pglm_pkg::back_status_type status
);

   logic [pglm_pkg::CHANNELS-1:0][pglm_pkg::PIX_W-1:0]  raw;
   logic [pglm_pkg::CHANNELS-1:0][pglm_pkg::PIX_W-1:0]  ram_q;
   logic [pglm_pkg::CHANNELS-1:0][pglm_pkg::PIX_W-1:0]  lut;
   logic [pglm_pkg::CHANNELS-1:0][pglm_pkg::SUM_W-1:0]  sum_ff, sum_in, sum_next;
   logic [pglm_pkg::CHANNELS-1:0][pglm_pkg::MEAN_W-1:0] mean;
   logic [pglm_pkg::CNT_W-1:0]                          cnt_ff, cnt_in, cnt_next;
   logic                                                counted;
   logic                                                room;
   logic                                                load_we;
   logic                                                pix_go;
   logic                                                div_start;
   logic                                                div_busy;

   logic                                                sb_valid_ff, sb_valid_in;
   logic                                                sb_last_ff;
   logic [pglm_pkg::CHANNELS-1:0][pglm_pkg::PIX_W-1:0]  sb_raw_ff;
   logic [pglm_pkg::PIX_W-1:0]                          sb_alpha_ff;
   pglm_pkg::rsp_type                                   sb_res;

   logic                                                hold_valid_ff, hold_valid_in;
   pglm_pkg::rsp_type                                   hold_ff;

   pglm_pkg::rsp_type                                   out_ff [pglm_pkg::OUT_DEPTH];
   pglm_pkg::rsp_type                                   push_data;
   logic                                                out_push;
   logic                                                out_take;
   logic [pglm_pkg::OUT_PW-1:0]                         wr_ptr_ff, wr_ptr_in;
   logic [pglm_pkg::OUT_PW-1:0]                         rd_ptr_ff, rd_ptr_in;
   logic [pglm_pkg::OUT_CW-1:0]                         out_cnt_ff, out_cnt_in;

   assign raw[0] = cmd_data.red;
   assign raw[1] = cmd_data.green;
   assign raw[2] = cmd_data.blue;

   // a pixel goes only when its result has a guaranteed slot downstream
   assign room = ({1'b0, out_cnt_ff} + (pglm_pkg::OUT_CW + 1)'(sb_valid_ff))
                 < (pglm_pkg::OUT_CW + 1)'(pglm_pkg::OUT_DEPTH);
   assign cmd_pop   = cmd_valid && !div_busy && !hold_valid_ff &&
                      (!cmd_data.is_pixel || room);
   assign load_we   = cmd_pop && !cmd_data.is_pixel;
   assign pix_go    = cmd_pop && cmd_data.is_pixel;
   assign div_start = pix_go && cmd_data.last;

   for (genvar c = 0; c < pglm_pkg::CHANNELS; c++) begin : g_lut
      pglm_ram #(
         .WIDTH (pglm_pkg::PIX_W),
         .DEPTH (pglm_pkg::TBL_DEPTH)
      ) u_ram (
         .clock (clock),
         .we    (load_we),
         .waddr (cmd_data.tbl_index),
         .wdata (cmd_data.tbl_value),
         .raddr (raw[c]),
         .rdata (ram_q[c])
      );
   end

   // accumulation saturates on the pixel count
   assign counted = (cnt_ff < pglm_pkg::CNT_W'(pglm_pkg::MAX_PIXELS));

   always_comb begin
      for (int c = 0; c < pglm_pkg::CHANNELS; c++) begin
         sum_next[c] = sum_ff[c] + (counted ? pglm_pkg::SUM_W'(raw[c]) : '0);
      end
      cnt_next = cnt_ff + pglm_pkg::CNT_W'(counted);
      sum_in   = sum_ff;
      cnt_in   = cnt_ff;
      if (pix_go) begin
         if (cmd_data.last) begin
            sum_in = '0;
            cnt_in = '0;
         end else begin
            sum_in = sum_next;
            cnt_in = cnt_next;
         end
      end
   end

   pglm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .sum   (sum_next),
      .count (cnt_next),
      .busy  (div_busy),
      .mean  (mean)
   );

   // lookup data arrives in the cycle after the pop
   always_comb begin
      for (int c = 0; c < pglm_pkg::CHANNELS; c++) begin
         lut[c] = bypass ? sb_raw_ff[c] : ram_q[c];
      end
      sb_res.out_red    = lut[0];
      sb_res.out_green  = lut[1];
      sb_res.out_blue   = lut[2];
      sb_res.out_alpha  = sb_alpha_ff;
      sb_res.mean_red   = '0;
      sb_res.mean_green = '0;
      sb_res.mean_blue  = '0;
      sb_res.image_done = 1'b0;
   end

   assign sb_valid_in = pix_go;

   // last pixel parks until the means are ready
   always_comb begin
      hold_valid_in = hold_valid_ff;
      push_data     = sb_res;
      out_push      = 1'b0;
      priority if (sb_valid_ff && sb_last_ff) begin
         hold_valid_in = 1'b1;
      end else if (sb_valid_ff) begin
         out_push = 1'b1;
      end else if (hold_valid_ff && !div_busy) begin
         out_push             = 1'b1;
         hold_valid_in        = 1'b0;
         push_data            = hold_ff;
         push_data.mean_red   = mean[0];
         push_data.mean_green = mean[1];
         push_data.mean_blue  = mean[2];
         push_data.image_done = 1'b1;
      end else begin
         hold_valid_in = hold_valid_ff;
      end
   end

   assign empty    = (out_cnt_ff == '0);
   assign out_take = pop && !empty;
   assign rsp_data = out_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (out_push) begin
         wr_ptr_in = (wr_ptr_ff == pglm_pkg::OUT_PW'(pglm_pkg::OUT_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (out_take) begin
         rd_ptr_in = (rd_ptr_ff == pglm_pkg::OUT_PW'(pglm_pkg::OUT_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({out_push, out_take})
         2'b10:   out_cnt_in = out_cnt_ff + 1'b1;
         2'b01:   out_cnt_in = out_cnt_ff - 1'b1;
         default: out_cnt_in = out_cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff        <= '0;
         cnt_ff        <= '0;
         sb_valid_ff   <= 1'b0;
         hold_valid_ff <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         out_cnt_ff    <= '0;
      end else begin
         sum_ff        <= sum_in;
         cnt_ff        <= cnt_in;
         sb_valid_ff   <= sb_valid_in;
         hold_valid_ff <= hold_valid_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         out_cnt_ff    <= out_cnt_in;
      end
      if (pix_go) begin
         sb_last_ff  <= cmd_data.last;
         sb_raw_ff   <= raw;
         sb_alpha_ff <= cmd_data.alpha;
      end
      if (sb_valid_ff && sb_last_ff) begin
         hold_ff <= sb_res;
      end
      if (out_push) begin
         out_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign status.div_busy   = div_busy;
   assign status.hold_valid = hold_valid_ff;
   assign status.out_count  = out_cnt_ff;

endmodule
`default_nettype wire

// ===== rtl/pixel_gamma_lut_with_mean_color_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_gamma_lut_with_mean_color_core
// RGBA gamma lookup through a loadable 256-entry table, with per-image
// mean colour in Q8.8 on the last pixel.
// ----------------------------------------------------------------------------
//  channel   ports                          direction  moves
//  request   push, full, req_data           in         table load or pixel
//  response  pop, empty, rsp_data           out        one result per pixel
//  control   psel..pwdata, prdata, pready   in/out     gamma_bypass register
//
//  Pixels and table loads run at one item per cycle when nothing stalls; a
//  pixel result is registered at lookup and then queued. A last pixel holds
//  the back end while the bit-serial divider forms the three means.
//  Reset clears sums, count and queues; the table itself is never cleared.
//  Input and result queues are four items deep, so either side may stall.
// ----------------------------------------------------------------------------
module pixel_gamma_lut_with_mean_color_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  pglm_pkg::req_type             req_data,
   output logic                          empty,
   input  logic                          pop,
   output pglm_pkg::rsp_type             rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [pglm_pkg::CSR_AW-1:0]   paddr,
   input  logic [pglm_pkg::CSR_DW-1:0]   pwdata,
   output logic [pglm_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready
);

   logic                      bypass_ff, bypass_in;
   logic                      csr_wr;
   logic                      csr_hit;
   logic                      cmd_valid;
   logic                      cmd_pop;
   pglm_pkg::cmd_type         cmd_data;
   pglm_pkg::back_status_type status;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_hit = (paddr[pglm_pkg::CSR_AW-1:2] == pglm_pkg::REG_GAMMA_BYPASS);

   always_comb begin
      bypass_in = bypass_ff;
      if (csr_wr && csr_hit) begin
         bypass_in = pwdata[0];
      end
   end

   assign prdata = csr_hit ? pglm_pkg::CSR_DW'(bypass_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff <= 1'b1;
      end else begin
         bypass_ff <= bypass_in;
      end
   end

   pglm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop)
   );

   pglm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .bypass    (bypass_ff),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .status    (status)
   );

   // result queue never overfills
   a_out_bound: assert property (@(posedge clock) disable iff (reset)
      status.out_count <= pglm_pkg::OUT_CW'(pglm_pkg::OUT_DEPTH))
      else $error("result queue overfilled");

   // divider only finishes with a last pixel waiting for it
   a_div_hold: assert property (@(posedge clock) disable iff (reset)
      $fell(status.div_busy) |-> status.hold_valid)
      else $error("means ready without a parked last pixel");

   // ordinary pixels carry zero means
   a_zero_mean: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.image_done) |->
      (rsp_data.mean_red == '0 && rsp_data.mean_green == '0 &&
       rsp_data.mean_blue == '0))
      else $error("non-zero mean on an ordinary pixel");

   // a mean never exceeds full scale
   a_mean_range: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.image_done) |->
      (rsp_data.mean_red <= pglm_pkg::MEAN_W'(pglm_pkg::MEAN_MAX) &&
       rsp_data.mean_green <= pglm_pkg::MEAN_W'(pglm_pkg::MEAN_MAX) &&
       rsp_data.mean_blue <= pglm_pkg::MEAN_W'(pglm_pkg::MEAN_MAX)))
      else $error("mean out of range");

endmodule
`default_nettype wire

// ===== sim/tb_pixel_gamma_lut_with_mean_color_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pixel_gamma_lut_with_mean_color_core
// Self-checking bench for the gamma table / mean colour core. A short table
// of directed items comes first, then random images mixed with table loads
// under three idling patterns. Results are checked against literal or predicted values.
// ----------------------------------------------------------------------------
module tb_pixel_gamma_lut_with_mean_color_core;

   localparam int LIMIT_CYCLES = 200000;
   localparam int SETTLE_CYCLES = 30;    // past the end of a divider run
   localparam int SEG_ITEMS = 50;
   localparam logic [pglm_pkg::CSR_AW-1:0] ADDR_GAMMA_BYPASS =
      {pglm_pkg::REG_GAMMA_BYPASS, 2'b00};
   localparam logic LOAD  = pglm_pkg::ACT_LOAD;
   localparam logic PIXEL = pglm_pkg::ACT_PIXEL;

   typedef struct packed {
      logic              is_cfg;
      logic              cfg_bypass;
      logic              lit;
      pglm_pkg::req_type item;
      pglm_pkg::rsp_type want;
   } dir_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          push = 1'b0;
   logic                          full;
   pglm_pkg::req_type             req_data = '0;
   logic                          empty;
   logic                          pop = 1'b0;
   pglm_pkg::rsp_type             rsp_data;
   logic                          psel = 1'b0;
   logic                          penable = 1'b0;
   logic                          pwrite = 1'b0;
   logic [pglm_pkg::CSR_AW-1:0]   paddr = '0;
   logic [pglm_pkg::CSR_DW-1:0]   pwdata = '0;
   logic [pglm_pkg::CSR_DW-1:0]   prdata;
   logic                          pready;

   // predictor state
   logic [pglm_pkg::PIX_W-1:0]    gamma_lut [pglm_pkg::TBL_DEPTH];
   bit                            lut_written [pglm_pkg::TBL_DEPTH];
   byte unsigned                  written_list [$];
   longint unsigned               sum_r, sum_g, sum_b;
   int unsigned                   pix_n;
   logic                          bypass_now = 1'b1;

   pglm_pkg::rsp_type             px_results_due [$];
   pglm_pkg::rsp_type             rx_want;
   dir_row_type                   dir_rows [$];
   int                            send_idle_pct = 32;
   int                            recv_idle_pct = 50;
   int                            mismatches = 0;
   int                            cycles = 0;

   pixel_gamma_lut_with_mean_color_core dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic void flag(input string what);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch at cycle %0d: %s", cycles, what);
   endfunction

   function automatic pglm_pkg::req_type mk_req(input logic act, input logic [7:0] ti, tv,
                                                input logic [7:0] r, g, b, a,
                                                input logic last);
      pglm_pkg::req_type q;
      q.action      = act;
      q.table_index = ti;
      q.table_value = tv;
      q.red         = r;
      q.green       = g;
      q.blue        = b;
      q.alpha       = a;
      q.last_pixel  = last;
      return q;
   endfunction

   function automatic pglm_pkg::rsp_type mk_rsp(input logic [7:0] r, g, b, a,
                                                input logic [15:0] mr, mg, mb,
                                                input logic done);
      pglm_pkg::rsp_type q;
      q.out_red    = r;
      q.out_green  = g;
      q.out_blue   = b;
      q.out_alpha  = a;
      q.mean_red   = mr;
      q.mean_green = mg;
      q.mean_blue  = mb;
      q.image_done = done;
      return q;
   endfunction

   function automatic dir_row_type row_item(input pglm_pkg::req_type it);
      return '{is_cfg: 1'b0, cfg_bypass: 1'b0, lit: 1'b0, item: it, want: '0};
   endfunction

   function automatic dir_row_type row_lit(input pglm_pkg::req_type it,
                                           input pglm_pkg::rsp_type w);
      return '{is_cfg: 1'b0, cfg_bypass: 1'b0, lit: 1'b1, item: it, want: w};
   endfunction

   function automatic dir_row_type row_cfg(input logic v);
      return '{is_cfg: 1'b1, cfg_bypass: v, lit: 1'b0, item: '0, want: '0};
   endfunction

   function automatic logic [pglm_pkg::PIX_W-1:0] gamma_of(
      input logic [pglm_pkg::PIX_W-1:0] v);
      return bypass_now ? v : gamma_lut[v];
   endfunction

   function automatic logic [pglm_pkg::MEAN_W-1:0] q88_mean(input longint unsigned s);
      return pglm_pkg::MEAN_W'((s << pglm_pkg::FRAC_W) / longint'(pix_n));
   endfunction

   // Advances the predictor by one item; returns 1 where a result is due.
   function automatic bit predict_pixel(input pglm_pkg::req_type it,
                                        output pglm_pkg::rsp_type r);
      r = '0;
      if (it.action == LOAD) begin
         gamma_lut[it.table_index] = it.table_value;
         if (!lut_written[it.table_index]) begin
            lut_written[it.table_index] = 1'b1;
            written_list.push_back(it.table_index);
         end
         return 1'b0;
      end
      r.out_red   = gamma_of(it.red);
      r.out_green = gamma_of(it.green);
      r.out_blue  = gamma_of(it.blue);
      r.out_alpha = it.alpha;
      // count saturates; later pixels are corrected but not summed
      if (pix_n < pglm_pkg::MAX_PIXELS) begin
         sum_r += it.red;
         sum_g += it.green;
         sum_b += it.blue;
         pix_n++;
      end
      if (it.last_pixel) begin
         r.mean_red   = q88_mean(sum_r);
         r.mean_green = q88_mean(sum_g);
         r.mean_blue  = q88_mean(sum_b);
         r.image_done = 1'b1;
         sum_r = 0;
         sum_g = 0;
         sum_b = 0;
         pix_n = 0;
      end
      return 1'b1;
   endfunction

   // With the table in use, only levels whose entry has been loaded are sent.
   function automatic logic [pglm_pkg::PIX_W-1:0] pick_level();
      logic [pglm_pkg::PIX_W-1:0] v;
      v = pglm_pkg::PIX_W'($urandom_range(255));
      if (!bypass_now && !lut_written[v])
         v = pglm_pkg::PIX_W'(written_list[$urandom_range(written_list.size() - 1)]);
      return v;
   endfunction

   task automatic push_item(input pglm_pkg::req_type it, input bit lit,
                            input pglm_pkg::rsp_type want);
      pglm_pkg::rsp_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (full) @(posedge clock);
      if (predict_pixel(it, r))
         px_results_due.push_back(lit ? want : r);
   endtask

   task automatic wait_quiet(input int settle);
      push <= 1'b0;
      while (px_results_due.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic set_bypass(input logic v);
      logic [pglm_pkg::CSR_DW-1:0] rd;
      wait_quiet(SETTLE_CYCLES);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_GAMMA_BYPASS;
      pwdata  <= pglm_pkg::CSR_DW'(v);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      bypass_now = v;
      // read back straight after
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rd = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (rd !== pglm_pkg::CSR_DW'(v))
         flag($sformatf("gamma_bypass read %h, wrote %0d", rd, v));
   endtask

   task automatic send_image(input int len, inout int sent);
      pglm_pkg::req_type it;
      for (int i = 0; i < len; i++) begin
         // stray table loads inside the image
         if ($urandom_range(9) == 0) begin
            it = pglm_pkg::req_type'({$urandom, $urandom});
            it.action = LOAD;
            push_item(it, 1'b0, '0);
            sent++;
         end
         it = pglm_pkg::req_type'({$urandom, $urandom});
         it.action     = PIXEL;
         it.red        = pick_level();
         it.green      = pick_level();
         it.blue       = pick_level();
         it.last_pixel = (i == len - 1);
         push_item(it, 1'b0, '0);
         sent++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (px_results_due.size() == 0) begin
               flag($sformatf("result with nothing expected: %p", rsp_data));
            end else begin
               rx_want = px_results_due.pop_front();
               if (rsp_data !== rx_want)
                  flag($sformatf("expected %p, got %p", rx_want, rsp_data));
            end
         end
         pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      int sent;
      int len;

      // bypass is set out of reset
      dir_rows.push_back(row_lit(mk_req(PIXEL, 0, 0, 0, 0, 0, 0, 1),
                                 mk_rsp(0, 0, 0, 0, 0, 0, 0, 1)));
      dir_rows.push_back(row_lit(mk_req(PIXEL, 0, 0, 255, 255, 255, 255, 1),
                                 mk_rsp(255, 255, 255, 255,
                                        16'hFF00, 16'hFF00, 16'hFF00, 1)));
      dir_rows.push_back(row_lit(mk_req(PIXEL, 0, 0, 1, 2, 3, 8'h80, 0),
                                 mk_rsp(1, 2, 3, 8'h80, 0, 0, 0, 0)));
      dir_rows.push_back(row_lit(mk_req(PIXEL, 0, 0, 3, 2, 1, 8'h7F, 1),
                                 mk_rsp(3, 2, 1, 8'h7F, 512, 512, 512, 1)));
      // table fields on a pixel are ignored
      dir_rows.push_back(row_item(mk_req(PIXEL, 8'h12, 8'h34, 8'hAA, 8'h55, 8'h0F, 1, 0)));
      dir_rows.push_back(row_item(mk_req(PIXEL, 8'hFF, 8'hFF, 8'h10, 8'h20, 8'h30, 2, 1)));
      // loads, with pixel fields that must be ignored
      dir_rows.push_back(row_item(mk_req(LOAD, 8'h00, 8'hFF, 255, 255, 255, 255, 1)));
      dir_rows.push_back(row_item(mk_req(LOAD, 8'hFF, 8'h00, 0, 0, 0, 0, 0)));
      dir_rows.push_back(row_item(mk_req(LOAD, 8'h10, 8'h5A, 8'h10, 0, 0, 0, 1)));
      dir_rows.push_back(row_item(mk_req(LOAD, 8'h80, 8'h01, 0, 0, 0, 0, 0)));
      dir_rows.push_back(row_item(mk_req(LOAD, 8'h7F, 8'hFE, 0, 0, 0, 0, 0)));
      dir_rows.push_back(row_cfg(1'b0));
      dir_rows.push_back(row_item(mk_req(PIXEL, 0, 0, 8'h00, 8'hFF, 8'h10, 8'hC3, 0)));
      dir_rows.push_back(row_item(mk_req(PIXEL, 0, 0, 8'h80, 8'h7F, 8'h00, 8'h00, 1)));
      // overwrite an entry already in use
      dir_rows.push_back(row_item(mk_req(LOAD, 8'h10, 8'hA5, 0, 0, 0, 0, 0)));
      dir_rows.push_back(row_item(mk_req(PIXEL, 0, 0, 8'h10, 8'h10, 8'h10, 8'h3C, 1)));
      dir_rows.push_back(row_item(mk_req(LOAD, 8'h55, 8'hAA, 8'h55, 8'h55, 8'h55, 8'h55, 1)));
      dir_rows.push_back(row_item(mk_req(PIXEL, 0, 0, 8'h55, 8'hFF, 8'h00, 8'hFF, 1)));
      dir_rows.push_back(row_cfg(1'b1));
      dir_rows.push_back(row_lit(mk_req(PIXEL, 0, 0, 8'h5A, 8'hA5, 8'h3C, 8'hE1, 1),
                                 mk_rsp(8'h5A, 8'hA5, 8'h3C, 8'hE1,
                                        16'h5A00, 16'hA500, 16'h3C00, 1)));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg)
            set_bypass(dir_rows[i].cfg_bypass);
         else
            push_item(dir_rows[i].item, dir_rows[i].lit, dir_rows[i].want);
      end

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 32;
               recv_idle_pct = 50;
            end
            1: begin
               send_idle_pct = 50;
               recv_idle_pct = 32;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int seg = 0; seg < 4; seg++) begin
            set_bypass(logic'((ph + seg + 1) % 2));
            sent = 0;
            while (sent < SEG_ITEMS) begin
               // now and then let the block run dry before the next image
               if ($urandom_range(19) == 0)
                  wait_quiet(0);
               len = ($urandom_range(9) == 0) ? $urandom_range(64, 20) : $urandom_range(12, 1);
               send_image(len, sent);
            end
         end
      end

      wait_quiet(SETTLE_CYCLES);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
